/* rtl/tsa_pkg.sv */
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and round functions of the table cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

    localparam int MAX_ROUNDS_DEF = 14;
    localparam int ROUND_CNT_W    = 4;
    localparam int IDX_W          = 16;
    localparam int BYTE_W         = 8;
    localparam int NUM_POS        = 16;
    localparam int TBL_AW         = 8;
    localparam int S_TDATA_W      = 152;
    localparam int M_TDATA_W      = 128;

    localparam logic [1:0] MODE_10 = 2'd0;
    localparam logic [1:0] MODE_12 = 2'd1;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_ENCRYPT = 1'b1;

    localparam logic [7:0] GF_POLY = 8'h1B;

    typedef logic [NUM_POS-1:0][BYTE_W-1:0] state_t;

    typedef struct packed {
        logic                    valid;
        logic                    func;
        logic [IDX_W-1:0]        tbl_idx;
        logic [BYTE_W-1:0]       tbl_byte;
        state_t                  st;
    } item_t;

    typedef struct packed {
        logic                    advance;
        logic [ROUND_CNT_W-1:0]  num_rounds;
    } ctrl_t;

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic state_t shift_rows(input state_t s);
        state_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[4*c+r] = s[4*((c+r)%4)+r];
            end
        end
        shift_rows = o;
    endfunction

    function automatic state_t mix_columns(input state_t s);
        state_t o;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = s[4*c];
            a1  = s[4*c+1];
            a2  = s[4*c+2];
            a3  = s[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
            o[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
            o[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
            o[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        mix_columns = o;
    endfunction

endpackage

`default_nettype wire

/* rtl/tsa_sbox_ram.sv */
// ----------------------------------------------------------------------------
// tsa_sbox_ram
// One 256 x 8 substitution table with a write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_sbox_ram
    import tsa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [TBL_AW-1:0] waddr,
    input  wire logic [BYTE_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [TBL_AW-1:0] raddr,
    output logic      [BYTE_W-1:0] rdata_reg
);

    logic [BYTE_W-1:0] mem [2**TBL_AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tsa_round.sv */
// ----------------------------------------------------------------------------
// tsa_round
// One cipher round: table lookup stage, then ShiftRows and MixColumns stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_round
    import tsa_pkg::*;
#(
    parameter int ROUND = 0
)
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire ctrl_t ctrl,
    input  wire item_t in_item,
    output item_t      out_item_reg
);

    localparam logic [ROUND_CNT_W-1:0] RIX = ROUND_CNT_W'(ROUND);

    item_t  a_item_reg;
    logic   a_active_reg;
    logic   a_last_reg;
    state_t sub_data;
    logic   wr_hit;

    // A table write lands when its request passes through this round.
    assign wr_hit = ctrl.advance && in_item.valid && (in_item.func == FUNC_WRITE)
                    && (in_item.tbl_idx[15:12] == RIX);

    for (genvar p = 0; p < NUM_POS; p++) begin : g_pos
        tsa_sbox_ram u_ram (
            .aclk      (aclk),
            .we        (wr_hit && (in_item.tbl_idx[11:8] == 4'(p))),
            .waddr     (in_item.tbl_idx[7:0]),
            .wdata     (in_item.tbl_byte),
            .re        (ctrl.advance),
            .raddr     (in_item.st[p]),
            .rdata_reg (sub_data[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_item_reg.valid   <= 1'b0;
            out_item_reg.valid <= 1'b0;
        end else if (ctrl.advance) begin
            a_item_reg.valid   <= in_item.valid;
            out_item_reg.valid <= a_item_reg.valid;
        end
        if (ctrl.advance) begin
            a_item_reg.func     <= in_item.func;
            a_item_reg.tbl_idx  <= in_item.tbl_idx;
            a_item_reg.tbl_byte <= in_item.tbl_byte;
            a_item_reg.st       <= in_item.st;
            a_active_reg        <= RIX < ctrl.num_rounds;
            a_last_reg          <= RIX == (ctrl.num_rounds - 1'b1);

            out_item_reg.func     <= a_item_reg.func;
            out_item_reg.tbl_idx  <= a_item_reg.tbl_idx;
            out_item_reg.tbl_byte <= a_item_reg.tbl_byte;
            if (!a_active_reg) begin
                out_item_reg.st <= a_item_reg.st;
            end else if (a_last_reg) begin
                out_item_reg.st <= shift_rows(sub_data);
            end else begin
                out_item_reg.st <= mix_columns(shift_rows(sub_data));
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/table_sbox_aes_round_cipher_unit.sv */
// ----------------------------------------------------------------------------
// table_sbox_aes_round_cipher_unit
// AES-shaped block cipher with a key-dependent substitution table per round
// and byte position.
// ----------------------------------------------------------------------------
// The unit is a linear pipeline of MAX_ROUNDS rounds, two register stages per
// round (the synchronous table RAM read, then ShiftRows and MixColumns), and
// a new request can be accepted in every cycle unless a stalled result holds
// the pipeline. Table writes travel down the same pipeline and update the
// tables of their round when they pass it, so writes and encryptions take
// effect strictly in request order. Encryptions that use fewer rounds than
// MAX_ROUNDS pass the unused rounds unchanged. Table entries have no defined
// value until written. round_mode may be changed only while the pipeline is
// empty. A stalled result holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module table_sbox_aes_round_cipher_unit
    import tsa_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
)
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write: round_mode in cfg_data.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_data,
    // Request channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata fields from bit 0: table_index[15:0], table_byte[23:16],
    // block_high[87:24], block_low[151:88].
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser fields from bit 0: func.
    input  wire logic                 s_tuser,
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata fields from bit 0: cipher_high[63:0], cipher_low[127:64].
    output logic      [M_TDATA_W-1:0] m_tdata
);

    logic [1:0]             round_mode_reg;
    logic [ROUND_CNT_W-1:0] num_rounds;
    ctrl_t                  ctrl;
    item_t                  in_item;
    item_t                  stage [MAX_ROUNDS+1];
    item_t                  last_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_mode_reg <= MODE_10;
        end else if (cfg_valid) begin
            round_mode_reg <= cfg_data;
        end
    end

    // Round count from the mode, clipped to the rounds that are built.
    always_comb begin
        unique case (round_mode_reg)
            MODE_10: num_rounds = ROUND_CNT_W'(10);
            MODE_12: num_rounds = ROUND_CNT_W'(12);
            default: num_rounds = ROUND_CNT_W'(14);
        endcase
        if (num_rounds > ROUND_CNT_W'(MAX_ROUNDS)) begin
            num_rounds = ROUND_CNT_W'(MAX_ROUNDS);
        end
    end

    // The pipeline moves unless a finished result waits at the output.
    // Table writes leave the pipeline silently at the end.
    assign last_item    = stage[MAX_ROUNDS];
    assign m_tvalid     = last_item.valid && (last_item.func == FUNC_ENCRYPT);
    assign ctrl.advance = !m_tvalid || m_tready;
    assign ctrl.num_rounds = num_rounds;
    assign s_tready     = ctrl.advance;

    // Unpack the request; plaintext byte 0 sits in the top bits of block_high.
    always_comb begin
        in_item.valid    = s_tvalid;
        in_item.func     = s_tuser;
        in_item.tbl_idx  = s_tdata[15:0];
        in_item.tbl_byte = s_tdata[23:16];
        for (int i = 0; i < 8; i++) begin
            in_item.st[i]   = s_tdata[24 + 63 - 8*i -: 8];
            in_item.st[8+i] = s_tdata[88 + 63 - 8*i -: 8];
        end
    end

    assign stage[0] = in_item;

    for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
        tsa_round #(
            .ROUND (r)
        ) u_round (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .in_item      (stage[r]),
            .out_item_reg (stage[r+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            m_tdata[63 - 8*i -: 8]  = last_item.st[i];
            m_tdata[127 - 8*i -: 8] = last_item.st[8+i];
        end
    end

endmodule

`default_nettype wire
